@@ design/y86_pkg.sv @@
`default_nettype none

package y86_pkg;

    localparam int NREGS = 15;
    localparam logic [3:0] RNONE = 4'hF;
    localparam logic [3:0] RSP   = 4'h4;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_INV   = 3'd2;
    localparam logic [2:0] ST_TRUNC = 3'd3;
    localparam logic [2:0] ST_MEMF  = 3'd4;
    localparam logic [2:0] ST_DIVZ  = 3'd5;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SETPC = 2'd1;
    localparam logic [1:0] MODE_STEP = 2'd2;

    localparam logic [3:0] IC_HALT   = 4'h0;
    localparam logic [3:0] IC_NOP    = 4'h1;
    localparam logic [3:0] IC_CMOV   = 4'h2;
    localparam logic [3:0] IC_IRMOV  = 4'h3;
    localparam logic [3:0] IC_RMMOV  = 4'h4;
    localparam logic [3:0] IC_MRMOV  = 4'h5;
    localparam logic [3:0] IC_OP     = 4'h6;
    localparam logic [3:0] IC_JXX    = 4'h7;
    localparam logic [3:0] IC_CALL   = 4'h8;
    localparam logic [3:0] IC_RET    = 4'h9;
    localparam logic [3:0] IC_PUSH   = 4'hA;
    localparam logic [3:0] IC_POP    = 4'hB;

    localparam logic [3:0] FN_ADD = 4'h0;
    localparam logic [3:0] FN_SUB = 4'h1;
    localparam logic [3:0] FN_AND = 4'h2;
    localparam logic [3:0] FN_XOR = 4'h3;
    localparam logic [3:0] FN_MUL = 4'h4;
    localparam logic [3:0] FN_DIV = 4'h5;
    localparam logic [3:0] FN_MOD = 4'h6;

    function automatic logic cond_holds(input logic [3:0] fn, input logic zf,
                                        input logic sf);
        logic r;
        case (fn)
            4'h0:    r = 1'b1;
            4'h1:    r = zf | sf;
            4'h2:    r = sf;
            4'h3:    r = zf;
            4'h4:    r = ~zf;
            4'h5:    r = ~sf;
            default: r = ~zf & ~sf;
        endcase
        return r;
    endfunction

    function automatic logic check_fields(input logic [3:0] ic, input logic [3:0] fn,
                                          input logic [3:0] ra, input logic [3:0] rb);
        logic r;
        if (fn > 4'd6)
        begin
            r = 1'b0;
        end
        else
        begin
            case (ic) inside
                IC_HALT, IC_NOP, IC_CALL, IC_RET: r = (fn == 4'd0);
                IC_CMOV, IC_OP:     r = (ra != RNONE) && (rb != RNONE);
                IC_IRMOV:           r = (fn == 4'd0) && (ra == RNONE) && (rb != RNONE);
                IC_RMMOV, IC_MRMOV: r = (fn == 4'd0) && (ra != RNONE) && (rb != RNONE);
                IC_JXX:             r = 1'b1;
                IC_PUSH, IC_POP:    r = (fn == 4'd0) && (ra != RNONE) && (rb == RNONE);
                default:            r = 1'b0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/y86_chan_if.sv @@
`default_nettype none

interface y86_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [63:0] start_pc;
    modport source (output valid, mode, load_address, load_byte, start_pc, input ready);
    modport sink (input valid, mode, load_address, load_byte, start_pc, output ready);
endinterface

interface y86_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [63:0] pc_after;
    logic [3:0]  opcode_seen;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [63:0] reg_value;
    logic        zero_flag;
    logic        sign_flag;
    modport source (output valid, status, pc_after, opcode_seen, reg_written, reg_index,
                    reg_value, zero_flag, sign_flag, input ready);
    modport sink (input valid, status, pc_after, opcode_seen, reg_written, reg_index,
                  reg_value, zero_flag, sign_flag, output ready);
endinterface

interface y86_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ design/y86_instruction_step_core.sv @@
// y86-64 step core: one item in, one result word out
// item channel: mode 0 writes load_byte at load_address, mode 1 sets the pc,
//   mode 2 fetches and executes one instruction at the pc, mode 3 does nothing
// cfg channel: memory_size_in_use, always ready, written between items
// result channel: status, pc after the item, icode, the reported register
//   write and the flags
// flow: load, set-pc and unused-mode items pass through the finish state into
//   the result register; the length of a step depends on the instruction and is
//   set by the byte-wide memory port (one byte per cycle for immediates and
//   quad-word data) and the register file with one read and one write port;
//   mul, div and mod step through the shared shift-add / restoring-divide
//   adder
// one item is in work at a time; item ready is high only when idle, and the
//   next item is taken while a finished result waits in the output register
// a stalled receiver holds the result; a finished item then waits for it
// reset clears registers, flags, pc and cfg (4096); memory is undefined
//   until written
`default_nettype none

module y86_instruction_step_core #(
    parameter int MEM_BYTES = 4096
) (
    input  wire          clk,
    input  wire          rst_n,
    y86_in_if.sink       item,
    y86_out_if.source    result,
    y86_cfg_if.sink      cfg
);

    localparam int AW = $clog2(MEM_BYTES);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_F0   = 5'd1;
    localparam logic [4:0] S_F0W  = 5'd2;
    localparam logic [4:0] S_F1   = 5'd3;
    localparam logic [4:0] S_F1W  = 5'd4;
    localparam logic [4:0] S_CHK  = 5'd5;
    localparam logic [4:0] S_LDI  = 5'd6;
    localparam logic [4:0] S_RDA  = 5'd7;
    localparam logic [4:0] S_RDB  = 5'd8;
    localparam logic [4:0] S_RDC  = 5'd9;
    localparam logic [4:0] S_EXE  = 5'd10;
    localparam logic [4:0] S_LDD  = 5'd11;
    localparam logic [4:0] S_WRQ  = 5'd12;
    localparam logic [4:0] S_MUL  = 5'd13;
    localparam logic [4:0] S_DIV  = 5'd14;
    localparam logic [4:0] S_CM1  = 5'd15;
    localparam logic [4:0] S_CM2  = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;

    logic [4:0]  state_reg;
    logic [12:0] cfg_reg;
    logic [63:0] pc_reg;
    logic        zf_reg, sf_reg;
    logic [3:0]  ic_reg, fn_reg, ra_reg, rb_reg;
    logic [63:0] valc_reg, valp_reg, vala_reg, valb_reg, addr_reg;
    logic [63:0] q_reg, wdata_reg;
    logic [63:0] x_reg, y_reg, acc_reg;
    logic [6:0]  cnt_reg;
    logic [2:0]  st_reg;
    logic [3:0]  op_reg;
    logic        rep_en_reg, w1_en_reg, fl_en_reg;
    logic [3:0]  rep_idx_reg, w1_idx_reg;
    logic [63:0] rep_val_reg, w1_val_reg;

    logic        o_valid_reg;
    logic [2:0]  o_status_reg;
    logic [63:0] o_pc_reg;
    logic [3:0]  o_op_reg;
    logic        o_wr_reg;
    logic [3:0]  o_idx_reg;
    logic [63:0] o_val_reg;
    logic        o_zf_reg, o_sf_reg;

    logic [7:0]  mem [0:MEM_BYTES-1];
    logic [7:0]  mem_q;
    logic [63:0] rf_mem [0:y86_pkg::NREGS-1];
    logic [y86_pkg::NREGS-1:0] rf_valid_reg;
    logic [63:0] rf_q;

    // effective limit and derived values
    logic [63:0] lim;
    logic [63:0] pc_inc1;
    logic        ld_ok;
    logic [AW-1:0] ld_idx, byte_idx;
    logic        need_imm;
    logic [63:0] chk_qaddr, chk_valp;
    logic [63:0] ea;
    logic        ea_ok, qaddr_ok;
    logic [63:0] ldq_v;
    logic [63:0] alu_v;
    logic        cond_ok;

    logic        mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;

    logic        rf_we;
    logic [3:0]  rf_wa, rf_ra;
    logic [63:0] rf_wd;

    // shared adder for multiply and divide
    logic [65:0] au_a, au_b, au_sum;
    logic        au_sub;
    logic [64:0] rem_sh;
    logic        div_neg;

    always_comb
    begin
        if (64'(cfg_reg) > 64'(MEM_BYTES))
            lim = 64'(MEM_BYTES);
        else
            lim = 64'(cfg_reg);
    end

    function automatic logic quad_ok(input logic [63:0] a, input logic [63:0] l);
        return (l >= 64'd8) && (a <= l - 64'd8);
    endfunction

    assign pc_inc1  = pc_reg + 64'd1;
    assign ld_ok    = 64'(item.load_address) < lim;
    assign ld_idx   = AW'(64'(item.load_address));
    assign byte_idx = addr_reg[AW-1:0] + AW'(cnt_reg[2:0]);
    assign ldq_v    = {mem_q, q_reg[63:8]};
    assign cond_ok  = y86_pkg::cond_holds(fn_reg, zf_reg, sf_reg);

    always_comb
    begin
        need_imm  = 1'b0;
        chk_qaddr = pc_reg + 64'd2;
        chk_valp  = pc_reg + 64'd2;
        case (ic_reg) inside
            y86_pkg::IC_IRMOV, y86_pkg::IC_RMMOV, y86_pkg::IC_MRMOV:
            begin
                need_imm = 1'b1;
                chk_valp = pc_reg + 64'd10;
            end
            y86_pkg::IC_JXX, y86_pkg::IC_CALL:
            begin
                need_imm  = 1'b1;
                chk_qaddr = pc_inc1;
                chk_valp  = pc_reg + 64'd9;
            end
            y86_pkg::IC_NOP, y86_pkg::IC_RET:
            begin
                chk_valp = pc_inc1;
            end
            default:
            begin
                chk_valp = pc_reg + 64'd2;
            end
        endcase
    end
    assign qaddr_ok = quad_ok(chk_qaddr, lim);

    always_comb
    begin
        case (ic_reg) inside
            y86_pkg::IC_RMMOV, y86_pkg::IC_MRMOV: ea = valb_reg + valc_reg;
            y86_pkg::IC_CALL, y86_pkg::IC_PUSH:   ea = valb_reg - 64'd8;
            default:                              ea = valb_reg;
        endcase
    end
    assign ea_ok = quad_ok(ea, lim);

    always_comb
    begin
        case (fn_reg)
            y86_pkg::FN_ADD: alu_v = valb_reg + vala_reg;
            y86_pkg::FN_SUB: alu_v = valb_reg - vala_reg;
            y86_pkg::FN_AND: alu_v = valb_reg & vala_reg;
            default:         alu_v = valb_reg ^ vala_reg;
        endcase
    end

    assign rem_sh = {acc_reg, x_reg[63]};
    always_comb
    begin
        if (state_reg == S_DIV)
        begin
            au_a   = {1'b0, rem_sh};
            au_b   = {2'b00, y_reg};
            au_sub = 1'b1;
        end
        else
        begin
            au_a   = {2'b00, acc_reg};
            au_b   = {2'b00, x_reg};
            au_sub = 1'b0;
        end
        au_sum = au_a + (au_sub ? ~au_b : au_b) + 66'(au_sub);
    end
    assign div_neg = au_sum[65];

    // byte memory ports
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ld_idx;
        mem_wd = item.load_byte;
        if (state_reg == S_IDLE && item.valid && item.mode == y86_pkg::MODE_LOAD && ld_ok)
            mem_we = 1'b1;
        else if (state_reg == S_WRQ)
        begin
            mem_we = 1'b1;
            mem_wa = byte_idx;
            mem_wd = wdata_reg[7:0];
        end
        if (state_reg == S_F0)
            mem_ra = pc_reg[AW-1:0];
        else if (state_reg == S_F1)
            mem_ra = pc_inc1[AW-1:0];
        else
            mem_ra = byte_idx;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        mem_q <= mem[mem_ra];
    end

    // register file ports
    always_comb
    begin
        if (state_reg == S_RDA)
            rf_ra = ra_reg;
        else if (ic_reg >= y86_pkg::IC_CALL)
            rf_ra = y86_pkg::RSP;
        else
            rf_ra = rb_reg;
        rf_we = 1'b0;
        rf_wa = rep_idx_reg;
        rf_wd = rep_val_reg;
        if (state_reg == S_CM1 && w1_en_reg)
        begin
            rf_we = 1'b1;
            rf_wa = w1_idx_reg;
            rf_wd = w1_val_reg;
        end
        else if (state_reg == S_CM2 && rep_en_reg)
            rf_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (rf_we && rf_wa != y86_pkg::RNONE)
            rf_mem[rf_wa] <= rf_wd;
        if (rf_ra != y86_pkg::RNONE && rf_valid_reg[rf_ra])
            rf_q <= rf_mem[rf_ra];
        else
            rf_q <= 64'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cfg_reg      <= 13'd4096;
            pc_reg       <= 64'd0;
            zf_reg       <= 1'b0;
            sf_reg       <= 1'b0;
            rf_valid_reg <= '0;
            ic_reg       <= 4'd0;
            fn_reg       <= 4'd0;
            ra_reg       <= y86_pkg::RNONE;
            rb_reg       <= y86_pkg::RNONE;
            valc_reg     <= 64'd0;
            valp_reg     <= 64'd0;
            vala_reg     <= 64'd0;
            valb_reg     <= 64'd0;
            addr_reg     <= 64'd0;
            q_reg        <= 64'd0;
            wdata_reg    <= 64'd0;
            x_reg        <= 64'd0;
            y_reg        <= 64'd0;
            acc_reg      <= 64'd0;
            cnt_reg      <= 7'd0;
            st_reg       <= y86_pkg::ST_OK;
            op_reg       <= 4'd0;
            rep_en_reg   <= 1'b0;
            rep_idx_reg  <= 4'd0;
            rep_val_reg  <= 64'd0;
            w1_en_reg    <= 1'b0;
            w1_idx_reg   <= 4'd0;
            w1_val_reg   <= 64'd0;
            fl_en_reg    <= 1'b0;
            o_valid_reg  <= 1'b0;
            o_status_reg <= y86_pkg::ST_OK;
            o_pc_reg     <= 64'd0;
            o_op_reg     <= 4'd0;
            o_wr_reg     <= 1'b0;
            o_idx_reg    <= 4'd0;
            o_val_reg    <= 64'd0;
            o_zf_reg     <= 1'b0;
            o_sf_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                cfg_reg <= cfg.data;
            if (o_valid_reg && result.ready && state_reg != S_FIN)
                o_valid_reg <= 1'b0;
            if (rf_we && rf_wa != y86_pkg::RNONE)
                rf_valid_reg[rf_wa] <= 1'b1;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        st_reg      <= y86_pkg::ST_OK;
                        op_reg      <= 4'd0;
                        rep_en_reg  <= 1'b0;
                        rep_idx_reg <= 4'd0;
                        rep_val_reg <= 64'd0;
                        w1_en_reg   <= 1'b0;
                        fl_en_reg   <= 1'b0;
                        state_reg   <= S_FIN;
                        case (item.mode)
                            y86_pkg::MODE_LOAD:
                            begin
                                if (!ld_ok)
                                    st_reg <= y86_pkg::ST_MEMF;
                            end
                            y86_pkg::MODE_SETPC: pc_reg <= item.start_pc;
                            y86_pkg::MODE_STEP:  state_reg <= S_F0;
                            default: ;
                        endcase
                    end
                end
                S_F0:
                begin
                    if (pc_reg >= lim)
                    begin
                        st_reg    <= y86_pkg::ST_TRUNC;
                        state_reg <= S_FIN;
                    end
                    else
                        state_reg <= S_F0W;
                end
                S_F0W:
                begin
                    ic_reg    <= mem_q[7:4];
                    fn_reg    <= mem_q[3:0];
                    op_reg    <= mem_q[7:4];
                    ra_reg    <= y86_pkg::RNONE;
                    rb_reg    <= y86_pkg::RNONE;
                    state_reg <= S_F1;
                end
                S_F1:
                begin
                    if (ic_reg > y86_pkg::IC_NOP)
                    begin
                        if (pc_inc1 >= lim)
                        begin
                            st_reg    <= y86_pkg::ST_TRUNC;
                            state_reg <= S_FIN;
                        end
                        else
                            state_reg <= S_F1W;
                    end
                    else
                        state_reg <= S_CHK;
                end
                S_F1W:
                begin
                    ra_reg    <= mem_q[7:4];
                    rb_reg    <= mem_q[3:0];
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    valp_reg <= chk_valp;
                    addr_reg <= chk_qaddr;
                    cnt_reg  <= 7'd0;
                    if (!y86_pkg::check_fields(ic_reg, fn_reg, ra_reg, rb_reg))
                    begin
                        st_reg    <= y86_pkg::ST_INV;
                        state_reg <= S_FIN;
                    end
                    else if (ic_reg == y86_pkg::IC_HALT)
                    begin
                        st_reg    <= y86_pkg::ST_HALT;
                        state_reg <= S_FIN;
                    end
                    else if (need_imm && !qaddr_ok)
                    begin
                        st_reg    <= y86_pkg::ST_TRUNC;
                        state_reg <= S_FIN;
                    end
                    else if (need_imm)
                        state_reg <= S_LDI;
                    else
                        state_reg <= S_RDA;
                end
                S_LDI:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0)
                        q_reg <= ldq_v;
                    if (cnt_reg == 7'd8)
                    begin
                        valc_reg  <= ldq_v;
                        state_reg <= S_RDA;
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB:
                begin
                    vala_reg  <= rf_q;
                    state_reg <= S_RDC;
                end
                S_RDC:
                begin
                    valb_reg  <= rf_q;
                    state_reg <= S_EXE;
                end
                S_EXE:
                begin
                    addr_reg  <= ea;
                    cnt_reg   <= 7'd0;
                    acc_reg   <= 64'd0;
                    x_reg     <= valb_reg;
                    y_reg     <= vala_reg;
                    state_reg <= S_CM1;
                    case (ic_reg)
                        y86_pkg::IC_CMOV:
                        begin
                            if (cond_ok)
                            begin
                                rep_en_reg  <= 1'b1;
                                rep_idx_reg <= rb_reg;
                                rep_val_reg <= vala_reg;
                            end
                        end
                        y86_pkg::IC_IRMOV:
                        begin
                            rep_en_reg  <= 1'b1;
                            rep_idx_reg <= rb_reg;
                            rep_val_reg <= valc_reg;
                        end
                        y86_pkg::IC_RMMOV, y86_pkg::IC_CALL, y86_pkg::IC_PUSH:
                        begin
                            if (!ea_ok)
                            begin
                                st_reg    <= y86_pkg::ST_MEMF;
                                state_reg <= S_FIN;
                            end
                            else
                            begin
                                state_reg <= S_WRQ;
                                if (ic_reg == y86_pkg::IC_RMMOV)
                                    wdata_reg <= vala_reg;
                                else
                                begin
                                    rep_en_reg  <= 1'b1;
                                    rep_idx_reg <= y86_pkg::RSP;
                                    rep_val_reg <= ea;
                                    if (ic_reg == y86_pkg::IC_CALL)
                                    begin
                                        wdata_reg <= valp_reg;
                                        valp_reg  <= valc_reg;
                                    end
                                    else
                                        wdata_reg <= vala_reg;
                                end
                            end
                        end
                        y86_pkg::IC_MRMOV, y86_pkg::IC_RET, y86_pkg::IC_POP:
                        begin
                            if (!ea_ok)
                            begin
                                st_reg    <= y86_pkg::ST_MEMF;
                                state_reg <= S_FIN;
                            end
                            else
                                state_reg <= S_LDD;
                        end
                        y86_pkg::IC_OP:
                        begin
                            rep_idx_reg <= rb_reg;
                            case (fn_reg) inside
                                y86_pkg::FN_ADD, y86_pkg::FN_SUB, y86_pkg::FN_AND,
                                y86_pkg::FN_XOR:
                                begin
                                    rep_en_reg  <= 1'b1;
                                    rep_val_reg <= alu_v;
                                    fl_en_reg   <= 1'b1;
                                end
                                y86_pkg::FN_MUL: state_reg <= S_MUL;
                                default:
                                begin
                                    if (vala_reg == 64'd0)
                                    begin
                                        st_reg    <= y86_pkg::ST_DIVZ;
                                        state_reg <= S_FIN;
                                    end
                                    else
                                        state_reg <= S_DIV;
                                end
                            endcase
                        end
                        y86_pkg::IC_JXX:
                        begin
                            if (cond_ok)
                                valp_reg <= valc_reg;
                        end
                        default: ;
                    endcase
                end
                S_LDD:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg != 7'd0)
                        q_reg <= ldq_v;
                    if (cnt_reg == 7'd8)
                    begin
                        state_reg  <= S_CM1;
                        rep_en_reg <= 1'b1;
                        if (ic_reg == y86_pkg::IC_RET)
                        begin
                            valp_reg    <= ldq_v;
                            rep_idx_reg <= y86_pkg::RSP;
                            rep_val_reg <= addr_reg + 64'd8;
                        end
                        else
                        begin
                            rep_idx_reg <= ra_reg;
                            rep_val_reg <= ldq_v;
                            // pop bumps the stack pointer first so a pop into it wins
                            if (ic_reg == y86_pkg::IC_POP)
                            begin
                                w1_en_reg  <= 1'b1;
                                w1_idx_reg <= y86_pkg::RSP;
                                w1_val_reg <= addr_reg + 64'd8;
                            end
                        end
                    end
                end
                S_WRQ:
                begin
                    cnt_reg   <= cnt_reg + 7'd1;
                    wdata_reg <= {8'd0, wdata_reg[63:8]};
                    if (cnt_reg == 7'd7)
                        state_reg <= S_CM1;
                end
                S_MUL:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    x_reg   <= {x_reg[62:0], 1'b0};
                    y_reg   <= {1'b0, y_reg[63:1]};
                    if (y_reg[0])
                        acc_reg <= au_sum[63:0];
                    if (cnt_reg == 7'd63)
                    begin
                        rep_en_reg  <= 1'b1;
                        rep_val_reg <= y_reg[0] ? au_sum[63:0] : acc_reg;
                        fl_en_reg   <= 1'b1;
                        state_reg   <= S_CM1;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    x_reg   <= {x_reg[62:0], ~div_neg};
                    acc_reg <= div_neg ? rem_sh[63:0] : au_sum[63:0];
                    if (cnt_reg == 7'd63)
                    begin
                        rep_en_reg <= 1'b1;
                        if (fn_reg == y86_pkg::FN_DIV)
                            rep_val_reg <= {x_reg[62:0], ~div_neg};
                        else
                            rep_val_reg <= div_neg ? rem_sh[63:0] : au_sum[63:0];
                        fl_en_reg <= 1'b1;
                        state_reg <= S_CM1;
                    end
                end
                S_CM1: state_reg <= S_CM2;
                S_CM2:
                begin
                    pc_reg <= valp_reg;
                    if (fl_en_reg)
                    begin
                        zf_reg <= (rep_val_reg == 64'd0);
                        sf_reg <= rep_val_reg[63];
                    end
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (!o_valid_reg || result.ready)
                    begin
                        o_valid_reg  <= 1'b1;
                        o_status_reg <= st_reg;
                        o_pc_reg     <= pc_reg;
                        o_op_reg     <= op_reg;
                        o_wr_reg     <= rep_en_reg && (st_reg == y86_pkg::ST_OK);
                        o_idx_reg    <= (st_reg == y86_pkg::ST_OK) ? rep_idx_reg : 4'd0;
                        o_val_reg    <= (st_reg == y86_pkg::ST_OK) ? rep_val_reg : 64'd0;
                        o_zf_reg     <= zf_reg;
                        o_sf_reg     <= sf_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign item.ready         = (state_reg == S_IDLE);
    assign cfg.ready          = 1'b1;
    assign result.valid       = o_valid_reg;
    assign result.status      = o_status_reg;
    assign result.pc_after    = o_pc_reg;
    assign result.opcode_seen = o_op_reg;
    assign result.reg_written = o_wr_reg;
    assign result.reg_index   = o_idx_reg;
    assign result.reg_value   = o_val_reg;
    assign result.zero_flag   = o_zf_reg;
    assign result.sign_flag   = o_sf_reg;

`ifndef SYNTHESIS
    a_step_not_immediate: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready && item.mode == y86_pkg::MODE_STEP)
        |=> (state_reg != S_IDLE))
        else $error("step item finished without any work");

    a_fault_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_status_reg != y86_pkg::ST_OK) |-> !o_wr_reg)
        else $error("faulting item reports a register write");

    a_written_index: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && o_wr_reg) |-> (o_idx_reg != y86_pkg::RNONE))
        else $error("register write to the no-register code");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && o_valid_reg && !result.ready) |=> (state_reg == S_FIN))
        else $error("result dropped while receiver stalled");
`endif

endmodule

`default_nettype wire
